/* hw/rtl/chunk_size_line_parser_assert.svh */
// Assertion macros for the checker file of the chunk-size line parser.
`ifndef CHUNK_SIZE_LINE_PARSER_ASSERT_SVH
`define CHUNK_SIZE_LINE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/csl_pkg.sv */
package csl_pkg;

  localparam int unsigned MaxDigitsDefault = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 64;
  localparam int unsigned CountW = 5;
  localparam int unsigned NibW = 4;

  localparam logic [ByteW-1:0] BYTE_CR = 8'h0D;
  localparam logic [ByteW-1:0] BYTE_LF = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_0 = 8'h30;
  localparam logic [ByteW-1:0] CHAR_9 = 8'h39;
  localparam logic [ByteW-1:0] CHAR_UA = 8'h41;
  localparam logic [ByteW-1:0] CHAR_UF = 8'h46;
  localparam logic [ByteW-1:0] CHAR_LA = 8'h61;
  localparam logic [ByteW-1:0] CHAR_LF = 8'h66;
  localparam logic [ByteW-1:0] LETTER_BASE = 8'd10;

  typedef enum logic [1:0] {
    ST_MORE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_TOO_BIG = 2'd3
  } line_status_t;

  typedef struct packed {
    line_status_t        status;
    logic [SizeW-1:0]    size;
    logic [CountW-1:0]   count;
  } csl_result_t;

  typedef struct packed {
    logic            valid;
    logic [NibW-1:0] nib;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [ByteW-1:0] b);
    hex_digit_t d;
    d.valid = 1'b1;
    d.nib = '0;
    priority if (b >= CHAR_0 && b <= CHAR_9) begin
      d.nib = NibW'(b - CHAR_0);
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      d.nib = NibW'(b - CHAR_UA + LETTER_BASE);
    end else if (b >= CHAR_LA && b <= CHAR_LF) begin
      d.nib = NibW'(b - CHAR_LA + LETTER_BASE);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

/* hw/rtl/chunk_size_line_parser.sv */
// Chunk-size line parser for chunked transfer coding.
// Input channel: one raw byte of the chunk-size line per transfer (in_valid,
// in_ready, in_byte_value). Result channel: exactly one result per input byte
// (out_valid, out_ready, out_line_status, out_chunk_size, out_digit_count).
// Status 0 means more bytes are needed, 1 means the line ended with the size
// in out_chunk_size, 2 flags an invalid line and 3 a size with too many digits.
// Hex digits are shifted into a 64-bit accumulator, most significant first.
// A byte accepted into the input register has its result registered in the
// result register when that register has room for it.
// Throughput: one byte per cycle while the receiver takes every result, set by the
// single registered pass through the decode and accumulate logic between the input and result registers.
// When the receiver stalls, the result register holds its transfer; the input
// register takes one more byte only if it is empty, and then in_ready falls.
// Reset clears both stage valid flags and the line state (no digits, not
// waiting for LF, zero size); in_ready is high in the first cycle after reset.
module chunk_size_line_parser
  import csl_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  in_byte_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_line_status,
  output logic [SizeW-1:0]  out_chunk_size,
  output logic [CountW-1:0] out_digit_count
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             take;
  csl_result_t      result;

  csl_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_value (in_byte_value),
    .take          (take),
    .s1_valid      (s1_valid),
    .s1_byte       (s1_byte)
  );

  csl_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (take),
    .byte_value (s1_byte),
    .result     (result)
  );

  csl_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .result          (result),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_status (out_line_status),
    .out_chunk_size  (out_chunk_size),
    .out_digit_count (out_digit_count)
  );

endmodule

/* hw/rtl/csl_in_stage.sv */
module csl_in_stage
  import csl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte_value,
  input  logic             take,
  output logic             s1_valid,
  output logic [ByteW-1:0] s1_byte
);

  logic             vld_r;
  logic             vld_nxt;
  logic [ByteW-1:0] byte_r;
  logic             load;

  assign in_ready = !vld_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    priority if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte_value;
    end
  end

  assign s1_valid = vld_r;
  assign s1_byte  = byte_r;

endmodule

/* hw/rtl/csl_core.sv */
module csl_core
  import csl_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [ByteW-1:0] byte_value,
  output csl_result_t      result
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_DIGITS);

  logic              awaiting_lf_r;
  logic              awaiting_lf_nxt;
  logic [CountW-1:0] digits_r;
  logic [CountW-1:0] digits_nxt;
  logic [SizeW-1:0]  acc_r;
  logic [SizeW-1:0]  acc_nxt;
  hex_digit_t        hex;
  logic              is_cr;
  logic              is_lf;

  assign hex   = hex_decode(byte_value);
  assign is_cr = (byte_value == BYTE_CR);
  assign is_lf = (byte_value == BYTE_LF);

  // Every outcome except a CR after digits or an accepted digit clears the line state.
  always_comb begin
    awaiting_lf_nxt = 1'b0;
    digits_nxt      = '0;
    acc_nxt         = '0;
    result.status   = ST_INVALID;
    result.size     = '0;
    result.count    = digits_r;
    priority if (awaiting_lf_r) begin
      if (is_lf && digits_r != '0) begin
        result.status = ST_DONE;
        result.size   = acc_r;
      end
    end else if (is_cr || is_lf) begin
      if (digits_r != '0) begin
        if (is_cr) begin
          awaiting_lf_nxt = 1'b1;
          digits_nxt      = digits_r;
          acc_nxt         = acc_r;
          result.status   = ST_MORE;
        end else begin
          result.status   = ST_DONE;
        end
        result.size = acc_r;
      end
    end else if (!hex.valid) begin
      result.status = ST_INVALID;
    end else if (digits_r >= MaxCount) begin
      result.status = ST_TOO_BIG;
    end else begin
      acc_nxt       = {acc_r[SizeW-NibW-1:0], hex.nib};
      digits_nxt    = digits_r + CountW'(1);
      result.status = ST_MORE;
      result.size   = acc_nxt;
      result.count  = digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_lf_r <= 1'b0;
      digits_r      <= '0;
      acc_r         <= '0;
    end else if (fire) begin
      awaiting_lf_r <= awaiting_lf_nxt;
      digits_r      <= digits_nxt;
      acc_r         <= acc_nxt;
    end
  end

endmodule

/* hw/rtl/csl_out_stage.sv */
module csl_out_stage
  import csl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  csl_result_t       result,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_line_status,
  output logic [SizeW-1:0]  out_chunk_size,
  output logic [CountW-1:0] out_digit_count
);

  logic        vld_r;
  logic        vld_nxt;
  csl_result_t res_r;
  logic        room;

  assign room = !vld_r || out_ready;
  assign take = room && s1_valid;

  always_comb begin
    vld_nxt = vld_r;
    if (room) begin
      vld_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

  assign out_valid       = vld_r;
  assign out_line_status = res_r.status;
  assign out_chunk_size  = res_r.size;
  assign out_digit_count = res_r.count;

endmodule

/* hw/rtl/csl_checker.sv */
`include "chunk_size_line_parser_assert.svh"

module csl_checker
  import csl_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MaxDigitsDefault
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_line_status,
  input logic [SizeW-1:0]  out_chunk_size,
  input logic [CountW-1:0] out_digit_count
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_DIGITS);
  localparam int unsigned ObsW = 1 + $bits(csl_result_t);

  logic [ObsW-1:0] out_obs;
  logic            out_stall;
  logic            out_big;
  logic            out_err;
  logic            out_done;
  logic            cnt_ok;
  logic            cnt_full;
  logic            cnt_zero;

  assign out_obs   = {out_valid, out_line_status, out_chunk_size, out_digit_count};
  assign out_stall = out_valid && !out_ready;
  assign out_big   = out_valid && (out_line_status == ST_TOO_BIG);
  assign out_err   = (out_valid && (out_line_status == ST_INVALID)) || out_big;
  assign out_done  = out_valid && (out_line_status == ST_DONE);
  assign cnt_ok    = (out_digit_count <= MaxCount);
  assign cnt_full  = (out_digit_count == MaxCount);
  assign cnt_zero  = (out_digit_count == '0);

  `CSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable(out_obs), "Stalled result changed")
  `CSL_ASSERT_SAME(a_err_zero, clk, rst_n, out_err, out_chunk_size == '0, "Error with nonzero size")
  `CSL_ASSERT_SAME(a_count_max, clk, rst_n, out_valid, cnt_ok, "Digit count over the limit")
  `CSL_ASSERT_SAME(a_too_big_full, clk, rst_n, out_big, cnt_full, "Too big without a full count")
  `CSL_ASSERT_SAME(a_done_digits, clk, rst_n, out_done, !cnt_zero, "Line done without digits")

endmodule

bind chunk_size_line_parser csl_checker #(.MAX_DIGITS(MAX_DIGITS)) u_csl_checker (.*);
